### rtl/vfse_pkg.sv
// shared types, codes and reset values of the varint frame string extractor
package vfse_pkg;

  localparam int unsigned LenWidthDefault = 20;
  localparam int unsigned CfgLenWidth     = 20;

  localparam logic [7:0]             ExpectedIdReset = 8'd0;
  localparam logic [CfgLenWidth-1:0] MaxLenReset     = 20'd131089;

  localparam logic CfgIdxExpectedId = 1'b0;
  localparam logic CfgIdxMaxLen     = 1'b1;

  localparam logic [1:0] KindHeader   = 2'd0;
  localparam logic [1:0] KindString   = 2'd1;
  localparam logic [1:0] KindError    = 2'd2;
  localparam logic [1:0] KindEmptyStr = 2'd3;

  localparam logic [2:0] ErrNone      = 3'd0;
  localparam logic [2:0] ErrVarintLen = 3'd1;
  localparam logic [2:0] ErrLenShort  = 3'd2;
  localparam logic [2:0] ErrBadId     = 3'd3;
  localparam logic [2:0] ErrStrLen    = 3'd4;
  localparam logic [2:0] ErrLenLarge  = 3'd5;

  typedef struct packed {
    logic [7:0] data;
    logic       cont;
    logic       id_match;
  } item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic       last;
    logic [2:0] error_code;
  } result_t;

endpackage

### rtl/vfse_front.sv
// front end: accepts stream bytes, classifies them and queues them for the parser
module vfse_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        in_data_i,
  input  logic [7:0]        expected_id_i,
  output logic              q_valid_o,
  input  logic              q_ready_i,
  output vfse_pkg::item_t   q_item_o
);

  vfse_pkg::item_t entry_q [2];
  logic            wr_ptr_q, wr_ptr_d;
  logic            rd_ptr_q, rd_ptr_d;
  logic [1:0]      count_q, count_d;
  logic            push, pop;
  vfse_pkg::item_t item_in;

  assign in_ready_o = (count_q != 2'd2);
  assign q_valid_o  = (count_q != 2'd0);
  assign q_item_o   = entry_q[rd_ptr_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_valid_o && q_ready_i;

  always_comb begin
    item_in.data     = in_data_i;
    item_in.cont     = in_data_i[7];
    item_in.id_match = (in_data_i == expected_id_i);
  end

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

### rtl/vfse_back.sv
// back end: packet parser state machine with a registered result stage
module vfse_back #(
  parameter int unsigned LEN_WIDTH = vfse_pkg::LenWidthDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               q_valid_i,
  output logic                               q_ready_o,
  input  vfse_pkg::item_t                    q_item_i,
  input  logic [vfse_pkg::CfgLenWidth-1:0]   max_len_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output vfse_pkg::result_t                  out_res_o
);

  localparam logic [2:0] PhPlen = 3'd0;
  localparam logic [2:0] PhId   = 3'd1;
  localparam logic [2:0] PhSlen = 3'd2;
  localparam logic [2:0] PhStr  = 3'd3;
  localparam logic [2:0] PhSkip = 3'd4;
  localparam logic [2:0] PhErr  = 3'd5;

  localparam logic [31:0] LenMask = 32'((64'd1 << LEN_WIDTH) - 64'd1);

  logic [2:0]           phase_q, phase_d;
  logic [31:0]          acc_q, acc_d;
  logic [2:0]           cnt_q, cnt_d;
  logic [LEN_WIDTH-1:0] pkt_left_q, pkt_left_d;
  logic [LEN_WIDTH-1:0] str_left_q, str_left_d;
  logic                 out_valid_q;
  vfse_pkg::result_t    res_q, res_d;

  logic                 accept;
  logic [6:0]           payload;
  logic [31:0]          part;
  logic [31:0]          acc_new;
  logic [31:0]          max_ext;
  logic [31:0]          limit;
  logic [LEN_WIDTH-1:0] pkt_dec;
  logic [LEN_WIDTH-1:0] str_dec;
  logic                 too_long;
  logic                 done;
  logic [2:0]           ecode;

  assign q_ready_o   = !out_valid_q || out_ready_i;
  assign accept      = q_valid_i && q_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

  assign payload  = q_item_i.data[6:0];
  assign acc_new  = acc_q | part;
  assign max_ext  = {{(32 - vfse_pkg::CfgLenWidth){1'b0}}, max_len_i};
  assign limit    = (max_ext < LenMask) ? max_ext : LenMask;
  assign pkt_dec  = pkt_left_q - LEN_WIDTH'(1);
  assign str_dec  = str_left_q - LEN_WIDTH'(1);
  assign done     = !q_item_i.cont;
  assign too_long = q_item_i.cont && (cnt_q == 3'd4);

  always_comb begin
    unique case (cnt_q)
      3'd0:    part = {25'd0, payload};
      3'd1:    part = {18'd0, payload, 7'd0};
      3'd2:    part = {11'd0, payload, 14'd0};
      3'd3:    part = {4'd0, payload, 21'd0};
      default: part = {payload[3:0], 28'd0};
    endcase
  end

  always_comb begin
    phase_d    = phase_q;
    acc_d      = acc_q;
    cnt_d      = cnt_q;
    pkt_left_d = pkt_left_q;
    str_left_d = str_left_q;
    ecode      = vfse_pkg::ErrNone;
    res_d.kind       = vfse_pkg::KindHeader;
    res_d.out_byte   = 8'd0;
    res_d.last       = 1'b0;
    res_d.error_code = vfse_pkg::ErrNone;

    unique case (phase_q)
      PhPlen: begin
        acc_d = acc_new;
        cnt_d = cnt_q + 3'd1;
        if (too_long) begin
          ecode = vfse_pkg::ErrVarintLen;
        end else if (done) begin
          if (acc_new[31] || (acc_new < 32'd2)) begin
            ecode = vfse_pkg::ErrLenShort;
          end else if (acc_new > limit) begin
            ecode = vfse_pkg::ErrLenLarge;
          end else begin
            pkt_left_d = acc_new[LEN_WIDTH-1:0];
            phase_d    = PhId;
          end
          acc_d = 32'd0;
          cnt_d = 3'd0;
        end
      end
      PhId: begin
        pkt_left_d = pkt_dec;
        if (!q_item_i.id_match) begin
          ecode = vfse_pkg::ErrBadId;
        end else begin
          phase_d = PhSlen;
        end
      end
      PhSlen: begin
        pkt_left_d = pkt_dec;
        acc_d      = acc_new;
        cnt_d      = cnt_q + 3'd1;
        if (too_long) begin
          ecode = vfse_pkg::ErrVarintLen;
        end else if (!done) begin
          if (pkt_dec == '0) begin
            ecode = vfse_pkg::ErrStrLen;
          end
        end else begin
          if (acc_new[31] || (acc_new > {{(32 - LEN_WIDTH){1'b0}}, pkt_dec})) begin
            ecode = vfse_pkg::ErrStrLen;
          end else if (acc_new == 32'd0) begin
            res_d.kind = vfse_pkg::KindEmptyStr;
            phase_d    = (pkt_dec == '0) ? PhPlen : PhSkip;
          end else begin
            str_left_d = acc_new[LEN_WIDTH-1:0];
            phase_d    = PhStr;
          end
          acc_d = 32'd0;
          cnt_d = 3'd0;
        end
      end
      PhStr: begin
        res_d.kind     = vfse_pkg::KindString;
        res_d.out_byte = q_item_i.data;
        pkt_left_d     = pkt_dec;
        str_left_d     = str_dec;
        if (str_dec == '0) begin
          res_d.last = 1'b1;
          phase_d    = (pkt_dec == '0) ? PhPlen : PhSkip;
        end
      end
      PhSkip: begin
        pkt_left_d = pkt_dec;
        if (pkt_dec == '0) begin
          phase_d = PhPlen;
        end
      end
      default: begin
        phase_d = PhErr;
      end
    endcase

    if (ecode != vfse_pkg::ErrNone) begin
      res_d.kind       = vfse_pkg::KindError;
      res_d.out_byte   = 8'd0;
      res_d.last       = 1'b0;
      res_d.error_code = ecode;
      phase_d          = PhErr;
      acc_d            = 32'd0;
      cnt_d            = 3'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhPlen;
      acc_q       <= 32'd0;
      cnt_q       <= 3'd0;
      pkt_left_q  <= '0;
      str_left_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        phase_q    <= phase_d;
        acc_q      <= acc_d;
        cnt_q      <= cnt_d;
        pkt_left_q <= pkt_left_d;
        str_left_q <= str_left_d;
      end
      if (q_ready_o) begin
        out_valid_q <= q_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

endmodule

### rtl/varint_frame_string_extractor.sv
// top level of the varint length-prefixed frame string extractor
//
//  channel  | dir | handshake                     | payload
//  s_axis   | in  | s_axis_tvalid / s_axis_tready | tdata[7:0] in_byte
//  m_axis   | out | m_axis_tvalid / m_axis_tready | tdata out_byte, error_code; tuser kind; tlast
//  cfg      | in  | cfg_valid_i / cfg_ready_o     | cfg_index_i, cfg_data_i
//
// one byte per cycle sustained while m_axis is not stalled; a result reaches m_axis through
// the queue entry and then the parser result register
// reset clears the queue, the parser state and the config registers to their reset values
// a stall on m_axis holds the result register; the two-entry queue absorbs the slack
// cfg writes are taken in any cycle and land in the next
module varint_frame_string_extractor #(
  parameter int unsigned LEN_WIDTH = vfse_pkg::LenWidthDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [7:0]                       s_axis_tdata,  // [7:0] in_byte
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [15:0]                      m_axis_tdata,  // [7:0] out_byte, [10:8] error_code
  output logic [1:0]                       m_axis_tuser,  // [1:0] kind
  output logic                             m_axis_tlast,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic                             cfg_index_i,
  input  logic [vfse_pkg::CfgLenWidth-1:0] cfg_data_i
);

  logic [7:0]                       expected_id_q;
  logic [vfse_pkg::CfgLenWidth-1:0] max_len_q;
  logic                             q_valid;
  logic                             q_ready;
  vfse_pkg::item_t                  q_item;
  vfse_pkg::result_t                res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_id_q <= vfse_pkg::ExpectedIdReset;
      max_len_q     <= vfse_pkg::MaxLenReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        vfse_pkg::CfgIdxExpectedId: expected_id_q <= cfg_data_i[7:0];
        default:                    max_len_q     <= cfg_data_i;
      endcase
    end
  end

  vfse_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_data_i     (s_axis_tdata),
    .expected_id_i (expected_id_q),
    .q_valid_o     (q_valid),
    .q_ready_i     (q_ready),
    .q_item_o      (q_item)
  );

  vfse_back #(
    .LEN_WIDTH (LEN_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_item_i    (q_item),
    .max_len_i   (max_len_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (res)
  );

  assign m_axis_tdata = {5'd0, res.error_code, res.out_byte};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

endmodule

### rtl/vfse_checker.sv
// port-level checker for the extractor output stream, bound to the top level
module vfse_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("output changed while stalled");

  a_last_on_string: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == vfse_pkg::KindString)
    else $error("tlast on a non-string transaction");

  a_code_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == vfse_pkg::KindError) ==
      (m_axis_tdata[10:8] != vfse_pkg::ErrNone))
    else $error("error code does not match kind");

  a_byte_on_string: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != vfse_pkg::KindString |-> m_axis_tdata[7:0] == 8'd0)
    else $error("data byte on a non-string transaction");

endmodule

bind varint_frame_string_extractor vfse_checker u_vfse_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
